FILE: rtl/msrb_pkg.sv
`timescale 1ns / 1ps

package msrb_pkg;

    localparam int RAM_ADDR_BITS = 10;
    localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;
    localparam int BUS_ADDR_BITS = 12;

    // access kinds
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // register selects
    localparam logic [2:0] SEL_P1_DATA = 3'd0;
    localparam logic [2:0] SEL_P2_DATA = 3'd1;
    localparam logic [2:0] SEL_P3_DATA = 3'd2;
    localparam logic [2:0] SEL_P4_DATA = 3'd3;
    localparam logic [2:0] SEL_P1_DIR  = 3'd4;
    localparam logic [2:0] SEL_P2_DIR  = 3'd5;
    localparam logic [2:0] SEL_P3_DIR  = 3'd6;
    localparam logic [2:0] SEL_P4_DIR  = 3'd7;

    // port bit roles
    localparam int P1_RW_BIT     = 7;
    localparam int P1_IRQ_BIT    = 6;
    localparam int P1_COIN_BIT   = 4;
    localparam int P2_STROBE_BIT = 4;

    // bus map
    localparam int ADDR_IO_BIT = 11;
    localparam logic [1:0] RAM_WINDOW = 2'b11;

    // switch / player sources by address low bits
    localparam logic [1:0] SRC_SW_A = 2'd0;
    localparam logic [1:0] SRC_SW_B = 2'd1;
    localparam logic [1:0] SRC_PL_A = 2'd2;
    localparam logic [1:0] SRC_PL_B = 2'd3;

    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [7:0] player_in_b;
        logic [7:0] player_in_a;
        logic [7:0] switch_bank_b;
        logic [7:0] switch_bank_a;
        logic [7:0] port4_pins;
        logic [7:0] port2_pins;
        logic [7:0] port1_pins;
        logic [7:0] write_data;
        logic [2:0] reg_select;
        logic       mode;
    } t_item;

    typedef struct packed {
        logic       coin_lockout;
        logic [7:0] irq_vector;
        logic       irq_pulse;
        logic [7:0] read_data;
    } t_result;

    typedef struct packed {
        logic                     en;
        logic [RAM_ADDR_BITS-1:0] addr;
        logic [7:0]               data;
    } t_ram_wr;

endpackage

FILE: rtl/msrb_ram.sv
`timescale 1ns / 1ps

module msrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/msrb_ports.sv
`timescale 1ns / 1ps

module msrb_ports (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  msrb_pkg::t_item                   i_acc_item,
    input  msrb_pkg::t_item                   i_item,
    input  logic                              i_exec,
    input  logic [7:0]                        i_ram_rdata,
    output logic [msrb_pkg::RAM_ADDR_BITS-1:0] o_rd_addr,
    output msrb_pkg::t_ram_wr                 o_ram_wr,
    output msrb_pkg::t_result                 o_result
);

    logic [7:0] r_dir   [4];
    logic [7:0] r_latch [4];
    logic [7:0] r_p3_in;

    logic [msrb_pkg::BUS_ADDR_BITS-1:0] w_addr;
    logic       w_strobe;
    logic       w_bus_rd;
    logic [7:0] w_pins;
    logic [7:0] w_src;
    logic [1:0] w_idx;

    assign w_idx = i_item.reg_select[1:0];

    // read address goes out with the accept so the data is back for execute
    always_comb begin
        if (i_acc_item.reg_select == msrb_pkg::SEL_P1_DATA) begin
            o_rd_addr = '0;
        end else begin
            o_rd_addr = {i_acc_item.write_data[msrb_pkg::RAM_ADDR_BITS-9:0], r_latch[3]};
        end
    end

    assign w_addr   = {i_item.write_data[3:0], r_latch[3]};
    assign w_strobe = (i_item.mode == msrb_pkg::MODE_WRITE)
                   && (i_item.reg_select == msrb_pkg::SEL_P2_DATA)
                   && !r_latch[1][msrb_pkg::P2_STROBE_BIT]
                   && i_item.write_data[msrb_pkg::P2_STROBE_BIT];
    assign w_bus_rd = r_latch[0][msrb_pkg::P1_RW_BIT];

    always_comb begin
        case (w_idx)
            2'd0:    w_pins = i_item.port1_pins;
            2'd1:    w_pins = i_item.port2_pins;
            2'd2:    w_pins = r_p3_in;
            default: w_pins = i_item.port4_pins;
        endcase
    end

    always_comb begin
        unique case (w_addr[1:0])
            msrb_pkg::SRC_SW_A: w_src = i_item.switch_bank_a;
            msrb_pkg::SRC_SW_B: w_src = i_item.switch_bank_b;
            msrb_pkg::SRC_PL_A: w_src = i_item.player_in_a;
            msrb_pkg::SRC_PL_B: w_src = i_item.player_in_b;
            default:            w_src = i_item.switch_bank_a;
        endcase
    end

    always_comb begin
        o_result = '0;
        if (i_item.mode == msrb_pkg::MODE_READ) begin
            if (i_item.reg_select[2]) begin
                o_result.read_data = r_dir[w_idx];
            end else begin
                o_result.read_data = (r_latch[w_idx] & r_dir[w_idx])
                                   | (w_pins & ~r_dir[w_idx]);
            end
        end else if (i_item.reg_select == msrb_pkg::SEL_P1_DATA) begin
            if (r_latch[0][msrb_pkg::P1_IRQ_BIT] && !i_item.write_data[msrb_pkg::P1_IRQ_BIT]) begin
                o_result.irq_pulse  = 1'b1;
                o_result.irq_vector = i_ram_rdata;
            end
        end
        if (i_item.mode == msrb_pkg::MODE_WRITE
                && i_item.reg_select == msrb_pkg::SEL_P1_DATA) begin
            o_result.coin_lockout = !i_item.write_data[msrb_pkg::P1_COIN_BIT];
        end else begin
            o_result.coin_lockout = !r_latch[0][msrb_pkg::P1_COIN_BIT];
        end
    end

    always_comb begin
        o_ram_wr.addr = w_addr[msrb_pkg::RAM_ADDR_BITS-1:0];
        o_ram_wr.data = r_latch[2];
        o_ram_wr.en   = i_exec && w_strobe && !w_bus_rd
                     && (w_addr[msrb_pkg::BUS_ADDR_BITS-1 -: 2] == msrb_pkg::RAM_WINDOW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_dir[i]   <= '0;
                r_latch[i] <= '0;
            end
            r_p3_in <= '0;
        end else if (i_exec) begin
            if (i_item.mode == msrb_pkg::MODE_WRITE) begin
                if (i_item.reg_select[2]) begin
                    r_dir[w_idx] <= i_item.write_data;
                end else begin
                    r_latch[w_idx] <= i_item.write_data;
                end
            end
            if (w_strobe && w_bus_rd) begin
                if (!w_addr[msrb_pkg::ADDR_IO_BIT]) begin
                    r_p3_in <= w_src;
                end else if (w_addr[msrb_pkg::BUS_ADDR_BITS-1 -: 2] == msrb_pkg::RAM_WINDOW) begin
                    r_p3_in <= i_ram_rdata;
                end
            end
        end
    end

endmodule

FILE: rtl/mcu_port_shared_ram_bridge.sv
// Flow: an accepted transfer is held in the item register, executes in the execute state and
//   its result waits in the output register; a stalled master side holds it there.
// Pacing: no transfer is taken while an item is in execute; the shared RAM read is registered.
// Reset: synchronous, active low; port registers clear at once, then a clearing pass
//   writes zero to all 1024 RAM bytes while the slave side is not ready.
`timescale 1ns / 1ps

module mcu_port_shared_ram_bridge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // write_data[7:0], port1_pins[15:8], port2_pins[23:16], port4_pins[31:24],
    // switch_bank_a[39:32], switch_bank_b[47:40], player_in_a[55:48], player_in_b[63:56]
    input  logic [msrb_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // mode[0], reg_select[3:1]
    input  logic [msrb_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // read_data[7:0], irq_pulse[8], irq_vector[16:9], coin_lockout[17], zero[23:18]
    output logic [msrb_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    msrb_pkg::t_state  r_state, n_state;
    msrb_pkg::t_item   w_acc_item, r_item;
    msrb_pkg::t_result w_result;
    msrb_pkg::t_ram_wr w_port_wr;

    logic [msrb_pkg::RAM_ADDR_BITS-1:0] r_clr_addr;
    logic [msrb_pkg::RAM_ADDR_BITS-1:0] w_rd_addr;
    logic [msrb_pkg::RAM_ADDR_BITS-1:0] w_waddr;
    logic [7:0]  w_wdata;
    logic        w_we;
    logic [7:0]  w_ram_rdata;
    logic        w_accept;
    logic        w_exec;
    logic        r_m_valid;
    logic [msrb_pkg::OUT_DATA_W-1:0] r_m_data;

    // unpack: tuser carries the access kind and select, tdata the rest
    assign w_acc_item = {i_s_axis_tdata, i_s_axis_tuser};

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // next state, slave ready, execute strobe and RAM write mux
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_exec          = 1'b0;
        w_we            = w_port_wr.en;
        w_waddr         = w_port_wr.addr;
        w_wdata         = w_port_wr.data;
        unique case (r_state)
            msrb_pkg::S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
                if (&r_clr_addr) begin
                    n_state = msrb_pkg::S_IDLE;
                end
            end
            msrb_pkg::S_IDLE: begin
                // accepted even while an earlier result waits at the master side
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = msrb_pkg::S_EXEC;
                end
            end
            msrb_pkg::S_EXEC: begin
                // RAM data for this item is valid now; wait only for a free output slot
                if (!r_m_valid || i_m_axis_tready) begin
                    w_exec  = 1'b1;
                    n_state = msrb_pkg::S_IDLE;
                end
            end
            default: n_state = msrb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= msrb_pkg::S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == msrb_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // item is held for the execute cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= w_acc_item;
        end
    end

    msrb_ports u_ports (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc_item  (w_acc_item),
        .i_item      (r_item),
        .i_exec      (w_exec),
        .i_ram_rdata (w_ram_rdata),
        .o_rd_addr   (w_rd_addr),
        .o_ram_wr    (w_port_wr),
        .o_result    (w_result)
    );

    // RAM read is issued with the accept, so a write from the previous item has landed
    msrb_ram #(
        .WIDTH (8),
        .DEPTH (msrb_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ram_rdata)
    );

    // output register parts the master side from the execute step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_exec) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_m_data <= {{(msrb_pkg::OUT_DATA_W - $bits(w_result)){1'b0}}, w_result};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

`ifndef ASSERT_OFF
    a_ram_we_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == msrb_pkg::S_CLEAR || w_exec))
        else $error("RAM write outside clear pass or execute");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == msrb_pkg::S_EXEC))
        else $error("accepted transfer did not reach execute");

    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> o_m_axis_tvalid)
        else $error("executed item produced no result");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msrb_pkg::S_CLEAR && (&r_clr_addr)) |=> (r_state == msrb_pkg::S_IDLE))
        else $error("clearing pass did not end");
`endif

endmodule

FILE: tb/mcu_port_shared_ram_bridge_test.sv
`timescale 1ns / 1ps

module mcu_port_shared_ram_bridge_test;
    import msrb_pkg::*;

    localparam int N_ACCESSES     = 1500;
    localparam int RX_HOLD_START  = 400;   // transfers accepted before the long output stall
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 20;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // write_data, port1_pins, port2_pins, port4_pins, switch_bank_a, switch_bank_b,
    // player_in_a, player_in_b (lowest byte first)
    logic [63:0] i_s_axis_tdata  = '0;
    // mode[0], reg_select[3:1]
    logic [3:0]  i_s_axis_tuser  = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // read_data[7:0], irq_pulse[8], irq_vector[16:9], coin_lockout[17], zero above
    logic [23:0] o_m_axis_tdata;

    mcu_port_shared_ram_bridge dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Port and shared RAM shadow state
    // ------------------------------------------------------------------
    logic [7:0] port_dir   [4];
    logic [7:0] port_latch [4];
    logic [7:0] port3_in;
    logic [7:0] shared_ram [RAM_DEPTH];

    // Applies one register access to the shadow state and returns the result it yields.
    function automatic t_result apply_port_access(t_item it);
        t_result                  r;
        logic [7:0]               pins;
        logic [BUS_ADDR_BITS-1:0] addr;
        logic [1:0]               idx;
        r   = '0;
        idx = it.reg_select[1:0];
        if (it.mode == MODE_READ) begin
            case (it.reg_select)
                SEL_P1_DIR, SEL_P2_DIR, SEL_P3_DIR, SEL_P4_DIR: begin
                    r.read_data = port_dir[idx];
                end
                default: begin
                    case (it.reg_select)
                        SEL_P1_DATA: pins = it.port1_pins;
                        SEL_P2_DATA: pins = it.port2_pins;
                        SEL_P3_DATA: pins = port3_in;   // port 3 pins come from the bus latch
                        default:     pins = it.port4_pins;
                    endcase
                    // output bits from the latch, input bits from the pins
                    r.read_data = (port_latch[idx] & port_dir[idx]) | (pins & ~port_dir[idx]);
                end
            endcase
        end else begin
            case (it.reg_select)
                SEL_P1_DIR, SEL_P2_DIR, SEL_P3_DIR, SEL_P4_DIR: begin
                    port_dir[idx] = it.write_data;
                end
                SEL_P1_DATA: begin
                    // falling edge on the irq bit raises the interrupt
                    if (port_latch[0][P1_IRQ_BIT] && !it.write_data[P1_IRQ_BIT]) begin
                        r.irq_pulse  = 1'b1;
                        r.irq_vector = shared_ram[0];
                    end
                    port_latch[0] = it.write_data;
                end
                SEL_P2_DATA: begin
                    // rising strobe starts one bus cycle; direction registers play no part
                    if (!port_latch[1][P2_STROBE_BIT] && it.write_data[P2_STROBE_BIT]) begin
                        addr = {it.write_data[3:0], port_latch[3]};
                        if (port_latch[0][P1_RW_BIT]) begin
                            if (!addr[ADDR_IO_BIT]) begin
                                case (addr[1:0])
                                    SRC_SW_A: port3_in = it.switch_bank_a;
                                    SRC_SW_B: port3_in = it.switch_bank_b;
                                    SRC_PL_A: port3_in = it.player_in_a;
                                    default:  port3_in = it.player_in_b;
                                endcase
                            end else if (addr[BUS_ADDR_BITS-1 -: 2] == RAM_WINDOW) begin
                                port3_in = shared_ram[addr[RAM_ADDR_BITS-1:0]];
                            end
                            // 0x800-0xBFF: latch keeps its value
                        end else if (addr[BUS_ADDR_BITS-1 -: 2] == RAM_WINDOW) begin
                            shared_ram[addr[RAM_ADDR_BITS-1:0]] = port_latch[2];
                        end
                    end
                    port_latch[1] = it.write_data;
                end
                default: begin
                    port_latch[idx] = it.write_data;
                end
            endcase
        end
        r.coin_lockout = !port_latch[0][P1_COIN_BIT];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    t_item   port_accesses[$];
    t_result port_access_results[$];

    function automatic logic [7:0] rand8();
        logic [31:0] w;
        w = $urandom;
        return w[7:0];
    endfunction

    // random byte, with all-zero and all-one values turning up often
    function automatic logic [7:0] edge_byte();
        logic [31:0] w;
        w = $urandom;
        case (w[11:8])
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return w[7:0];
        endcase
    endfunction

    // bus address biased toward a few RAM bytes so that reads hit earlier writes
    function automatic logic [BUS_ADDR_BITS-1:0] pick_bus_addr();
        logic [31:0] w;
        w = $urandom;
        case (w[31:29])
            0, 1, 2: return {RAM_WINDOW, 6'h00, w[3:0]};   // includes the vector byte
            3:       return {RAM_WINDOW, 6'h3F, w[3:0]};
            4:       return {1'b0, w[10:0]};               // switches and player inputs
            5:       return {2'b10, w[9:0]};               // unmapped hole
            default: return w[11:0];
        endcase
    endfunction

    task automatic push_access(input logic m, input logic [2:0] sel, input logic [7:0] d);
        t_item it;
        it.mode          = m;
        it.reg_select    = sel;
        it.write_data    = d;
        it.port1_pins    = edge_byte();
        it.port2_pins    = edge_byte();
        it.port4_pins    = edge_byte();
        it.switch_bank_a = rand8();
        it.switch_bank_b = rand8();
        it.player_in_a   = rand8();
        it.player_in_b   = rand8();
        port_accesses.push_back(it);
    endtask

    // full bus cycle: r/w select on port 1, data on port 3 for writes,
    // address low byte on port 4, then strobe low and high on port 2
    task automatic bus_cycle(input logic rw, input logic [BUS_ADDR_BITS-1:0] addr);
        logic [7:0] p1;
        logic [7:0] p2;
        p1             = rand8();
        p1[P1_RW_BIT]  = rw;
        push_access(MODE_WRITE, SEL_P1_DATA, p1);
        if (!rw) push_access(MODE_WRITE, SEL_P3_DATA, edge_byte());
        push_access(MODE_WRITE, SEL_P4_DATA, addr[7:0]);
        p2                = rand8();
        p2[P2_STROBE_BIT] = 1'b0;
        push_access(MODE_WRITE, SEL_P2_DATA, p2);
        p2[3:0]           = addr[11:8];
        p2[P2_STROBE_BIT] = 1'b1;
        push_access(MODE_WRITE, SEL_P2_DATA, p2);
    endtask

    // random idle cycles per transfer, with occasional runs of back-to-back transfers
    function automatic int next_wait(inout int streak);
        if (streak > 0) begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 30) == 0) streak = 40;
        return $urandom_range(0, 10);
    endfunction

    // ------------------------------------------------------------------
    // Input side: drives queued accesses, predicts on each accepted transfer
    // ------------------------------------------------------------------
    t_item tx_item;
    int    tx_gap    = 0;
    int    tx_streak = 0;
    int    accepted  = 0;
    logic  hold_rx   = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) begin
                port_access_results.push_back(apply_port_access(tx_item));
                accepted++;
                // keep offering back to back while the output is held off
                tx_gap = hold_rx ? 0 : next_wait(tx_streak);
            end
            if (tx_gap > 0) begin
                tx_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (port_accesses.size() > 0) begin
                tx_item = port_accesses.pop_front();
                i_s_axis_tdata <= {tx_item.player_in_b, tx_item.player_in_a,
                                   tx_item.switch_bank_b, tx_item.switch_bank_a,
                                   tx_item.port4_pins, tx_item.port2_pins,
                                   tx_item.port1_pins, tx_item.write_data};
                i_s_axis_tuser  <= {tx_item.reg_select, tx_item.mode};
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random ready, field-by-field compare against the oldest prediction
    // ------------------------------------------------------------------
    t_result rx_got;
    t_result rx_want;
    int      rx_gap    = 0;
    int      rx_streak = 0;
    int      errors    = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                rx_got = o_m_axis_tdata[$bits(t_result)-1:0];
                if (port_access_results.size() == 0) begin
                    $error("result transfer with nothing predicted: tdata %h", o_m_axis_tdata);
                    errors++;
                end else begin
                    rx_want = port_access_results.pop_front();
                    if (rx_got.read_data !== rx_want.read_data) begin
                        $error("read_data: expected %h, got %h",
                               rx_want.read_data, rx_got.read_data);
                        errors++;
                    end
                    if (rx_got.irq_pulse !== rx_want.irq_pulse) begin
                        $error("irq_pulse: expected %b, got %b",
                               rx_want.irq_pulse, rx_got.irq_pulse);
                        errors++;
                    end
                    if (rx_got.irq_vector !== rx_want.irq_vector) begin
                        $error("irq_vector: expected %h, got %h",
                               rx_want.irq_vector, rx_got.irq_vector);
                        errors++;
                    end
                    if (rx_got.coin_lockout !== rx_want.coin_lockout) begin
                        $error("coin_lockout: expected %b, got %b",
                               rx_want.coin_lockout, rx_got.coin_lockout);
                        errors++;
                    end
                end
                rx_gap = next_wait(rx_streak);
            end
            if (hold_rx) begin
                i_m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // one long output stall so the block backs up and drops its input ready
    initial begin
        while (accepted < RX_HOLD_START) @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequence: fill the access queue, reset, drain, report
    // ------------------------------------------------------------------
    initial begin
        logic [2:0]               sel;
        logic [BUS_ADDR_BITS-1:0] addr;
        logic [31:0]              w;
        logic [7:0]               p1;
        int                       total;

        for (int i = 0; i < 4; i++) begin
            port_dir[i]   = '0;
            port_latch[i] = '0;
        end
        port3_in = '0;
        for (int i = 0; i < RAM_DEPTH; i++) shared_ram[i] = '0;

        // directed: every register read out of reset
        sel = SEL_P1_DATA;
        repeat (8) begin
            push_access(MODE_READ, sel, rand8());
            sel++;
        end
        push_access(MODE_WRITE, SEL_P1_DIR, 8'hFF);
        push_access(MODE_WRITE, SEL_P3_DIR, 8'hAA);
        // read cycles selected, irq bit armed, coin bit low
        push_access(MODE_WRITE, SEL_P1_DATA, 8'hC0);
        // bus read of the first switch bank at 0x000
        push_access(MODE_WRITE, SEL_P4_DATA, 8'h00);
        push_access(MODE_WRITE, SEL_P2_DATA, 8'h00);
        push_access(MODE_WRITE, SEL_P2_DATA, 8'h10);
        push_access(MODE_READ, SEL_P3_DATA, 8'h00);
        // bus read of the top RAM byte at 0xFFF
        push_access(MODE_WRITE, SEL_P4_DATA, 8'hFF);
        push_access(MODE_WRITE, SEL_P2_DATA, 8'h0F);
        push_access(MODE_WRITE, SEL_P2_DATA, 8'h1F);
        // unmapped read at 0xBFF leaves the port 3 latch alone
        push_access(MODE_WRITE, SEL_P2_DATA, 8'h0B);
        push_access(MODE_WRITE, SEL_P2_DATA, 8'h1B);
        push_access(MODE_READ, SEL_P3_DATA, 8'hFF);
        // write cycles, irq bit falls, coins released
        push_access(MODE_WRITE, SEL_P1_DATA, 8'h10);
        // 0xFF into the vector byte at 0xC00
        push_access(MODE_WRITE, SEL_P3_DATA, 8'hFF);
        push_access(MODE_WRITE, SEL_P4_DATA, 8'h00);
        push_access(MODE_WRITE, SEL_P2_DATA, 8'h0C);
        push_access(MODE_WRITE, SEL_P2_DATA, 8'h1C);
        // write outside the RAM window is dropped
        push_access(MODE_WRITE, SEL_P2_DATA, 8'h07);
        push_access(MODE_WRITE, SEL_P2_DATA, 8'h17);
        // interrupt carrying the new vector
        push_access(MODE_WRITE, SEL_P1_DATA, 8'h40);
        push_access(MODE_WRITE, SEL_P1_DATA, 8'h00);

        // random: mostly complete bus cycles with random content, some interrupt pulses, the rest noise
        while (port_accesses.size() < N_ACCESSES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    bus_cycle(1'b0, pick_bus_addr());
                end
                4, 5, 6: begin
                    addr = pick_bus_addr();
                    bus_cycle(1'b1, addr);
                    if ($urandom_range(0, 2) == 0)
                        push_access(MODE_WRITE, SEL_P3_DIR, edge_byte());
                    push_access(MODE_READ, SEL_P3_DATA, rand8());
                end
                7: begin
                    p1             = rand8();
                    p1[P1_IRQ_BIT] = 1'b1;
                    push_access(MODE_WRITE, SEL_P1_DATA, p1);
                    p1             = rand8();
                    p1[P1_IRQ_BIT] = 1'b0;
                    push_access(MODE_WRITE, SEL_P1_DATA, p1);
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        w = $urandom;
                        push_access(w[0], w[3:1], edge_byte());
                    end
                end
            endcase
        end
        total = port_accesses.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted < total) @(posedge i_clk);
        while (port_access_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog: well beyond the slowest legal run (RAM clear, all gaps, long stall)
    initial begin
        #(5_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
